>>> hw/rtl/dfsa_pkg.sv
// Shared types and constants for the deferred free slot allocator.
// Holds payload structs, function and status codes, and register indexes.
// No dependencies.
package dfsa_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int FRAME_SLOTS  = 3;

    localparam int ELEM_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W   = ELEM_W + 1;
    localparam int SLOT_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int RS_AW   = SLOT_W + ELEM_W;
    localparam int RS_DEPTH = FRAME_SLOTS * MAX_ELEMENTS;

    // Function codes
    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_FRAME   = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_COUNT   = 3'd1;
    localparam logic [2:0] ST_NO_SPACE    = 3'd2;
    localparam logic [2:0] ST_FOREIGN     = 3'd3;
    localparam logic [2:0] ST_RETIRE_FULL = 3'd4;

    // Configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_HANDLE   = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  count;
        logic [9:0]  element;
        logic [15:0] handle;
        logic [1:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  index;
        logic [10:0] free_count;
        logic [10:0] next_unused;
    } t_out_item;

endpackage

>>> hw/rtl/deferred_free_slot_allocator.sv
// Top level of the deferred free slot allocator: sequencer, free stack and
// retire list memories, APB-style configuration registers.
// Depends on dfsa_pkg.
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_ready, payload
//   i_in) and every request produces exactly one result on the output
//   channel (o_out_valid / i_out_ready, payload o_out).
//   A small sequencer drives one memory access per cycle, so the block takes
//   one request at a time and drops o_in_ready until that request's result
//   is loaded into the output register.
//   An allocate served from the counter, a release, a rejected request or a
//   frame start to a missing slot goes from the execute state straight to the
//   result load; an allocate popped from the free stack first does one free
//   stack read; a frame start that moves n retired entries does a retire list
//   read followed by a free stack write for each entry. o_in_ready rises
//   again with the load, so a new request is taken only once the last result
//   has been loaded into the output register.
//   The output register parts the two sides: a finished result waits there
//   while the next request is taken. If the receiver stalls with a result
//   still waiting, the next result holds in the sequencer until the output
//   register frees up.
//   Reset (synchronous, active low) empties the free stack, the bump counter
//   and every retire list and clears both configuration registers. Memory
//   contents are not cleared; only entries below the stack top or a list
//   length are ever read.
//   Configuration: capacity at byte address 0, primary handle at address 4.
module deferred_free_slot_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dfsa_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dfsa_pkg::t_out_item  o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int ELEM_W = dfsa_pkg::ELEM_W;
    localparam int CNT_W  = dfsa_pkg::CNT_W;
    localparam int SLOT_W = dfsa_pkg::SLOT_W;
    localparam int RS_AW  = dfsa_pkg::RS_AW;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(dfsa_pkg::MAX_ELEMENTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } t_state;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [10:0] r_capacity;
    logic [15:0] r_primary_handle;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity       <= '0;
            r_primary_handle <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == dfsa_pkg::REG_CAPACITY) begin
                r_capacity <= pwdata[10:0];
            end else begin
                r_primary_handle <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == dfsa_pkg::REG_CAPACITY) begin
            prdata = {21'd0, r_capacity};
        end else begin
            prdata = {16'd0, r_primary_handle};
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    t_state              r_state, n_state;
    dfsa_pkg::t_in_item  r_item, n_item;
    logic [CNT_W-1:0]    r_free_top, n_free_top;
    logic [CNT_W-1:0]    r_bump, n_bump;
    logic [CNT_W-1:0]    r_len [dfsa_pkg::FRAME_SLOTS];
    logic [CNT_W-1:0]    n_len [dfsa_pkg::FRAME_SLOTS];
    logic [CNT_W-1:0]    r_k, n_k;
    logic [2:0]          r_res_status, n_res_status;
    logic [ELEM_W-1:0]   r_res_index, n_res_index;
    logic                r_out_valid, n_out_valid;
    dfsa_pkg::t_out_item r_out, n_out;

    // Memory ports
    logic [ELEM_W-1:0]   r_free_stack [dfsa_pkg::MAX_ELEMENTS];
    logic [ELEM_W-1:0]   r_retire_store [dfsa_pkg::RS_DEPTH];
    logic [ELEM_W-1:0]   r_fs_rdata;
    logic [ELEM_W-1:0]   r_rs_rdata;
    logic                fs_we, fs_re, rs_we, rs_re;
    logic [ELEM_W-1:0]   fs_raddr, fs_waddr;
    logic [RS_AW-1:0]    rs_raddr, rs_waddr;

    // Helpers decoded from the held request
    logic [SLOT_W-1:0]   slot_idx;
    logic                slot_ok;
    logic [CNT_W-1:0]    len_cur;
    logic [CNT_W-1:0]    top_dec;
    logic                bump_ok;

    assign slot_idx = r_item.slot[SLOT_W-1:0];
    assign slot_ok  = ({1'b0, r_item.slot} < 3'(dfsa_pkg::FRAME_SLOTS));
    assign len_cur  = slot_ok ? r_len[slot_idx] : '0;
    assign top_dec  = r_free_top - 1'b1;
    // Capacity above the array size acts as the array size.
    assign bump_ok  = (r_bump < r_capacity) && (r_bump < MAX_CNT);

    assign fs_raddr = top_dec[ELEM_W-1:0];
    assign fs_waddr = r_free_top[ELEM_W-1:0];
    assign rs_waddr = {slot_idx, len_cur[ELEM_W-1:0]};
    assign rs_raddr = {slot_idx, r_k[ELEM_W-1:0]};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_free_top   = r_free_top;
        n_bump       = r_bump;
        n_len        = r_len;
        n_k          = r_k;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        fs_we        = 1'b0;
        fs_re        = 1'b0;
        rs_we        = 1'b0;
        rs_re        = 1'b0;

        // Drop the result once the receiver takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = dfsa_pkg::ST_OK;
                n_res_index  = '0;
                n_state      = S_DONE;
                case (r_item.func)
                    dfsa_pkg::FN_ALLOC: begin
                        if (r_item.count != 8'd1) begin
                            n_res_status = dfsa_pkg::ST_BAD_COUNT;
                        end else if (r_free_top != '0) begin
                            // Pop: read the entry below the top, data next cycle.
                            fs_re      = 1'b1;
                            n_free_top = top_dec;
                            n_state    = S_POP;
                        end else if (bump_ok) begin
                            n_res_index = r_bump[ELEM_W-1:0];
                            n_bump      = r_bump + 1'b1;
                        end else begin
                            n_res_status = dfsa_pkg::ST_NO_SPACE;
                        end
                    end
                    dfsa_pkg::FN_RELEASE: begin
                        if (r_item.handle != r_primary_handle) begin
                            n_res_status = dfsa_pkg::ST_FOREIGN;
                        end else if (!slot_ok || (len_cur >= MAX_CNT)) begin
                            n_res_status = dfsa_pkg::ST_RETIRE_FULL;
                        end else begin
                            rs_we             = 1'b1;
                            n_len[slot_idx]   = len_cur + 1'b1;
                        end
                    end
                    dfsa_pkg::FN_FRAME: begin
                        if (slot_ok) begin
                            n_k     = '0;
                            n_state = S_COPY_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                n_res_index = r_fs_rdata;
                n_state     = S_DONE;
            end
            S_COPY_RD: begin
                // Advance through the retire list oldest first; stop when the
                // list runs out or the free stack fills up.
                if ((r_k < len_cur) && (r_free_top < MAX_CNT)) begin
                    rs_re   = 1'b1;
                    n_state = S_COPY_WR;
                end else begin
                    n_len[slot_idx] = '0;
                    n_state         = S_DONE;
                end
            end
            S_COPY_WR: begin
                fs_we      = 1'b1;
                n_free_top = r_free_top + 1'b1;
                n_k        = r_k + 1'b1;
                n_state    = S_COPY_RD;
            end
            S_DONE: begin
                // Hold here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_res_status;
                    n_out.index       = r_res_index;
                    n_out.free_count  = r_free_top;
                    n_out.next_unused = r_bump;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_top  <= '0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < dfsa_pkg::FRAME_SLOTS; s++) begin
                r_len[s] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_free_top  <= n_free_top;
            r_bump      <= n_bump;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
        end
        r_item       <= n_item;
        r_k          <= n_k;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out        <= n_out;
    end

    // ---------------------------------------------------------------------
    // Memories: one write and one registered read each per cycle
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_free_stack[fs_waddr] <= r_rs_rdata;
        end
        if (fs_re) begin
            r_fs_rdata <= r_free_stack[fs_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_retire_store[rs_waddr] <= r_item.element;
        end
        if (rs_re) begin
            r_rs_rdata <= r_retire_store[rs_raddr];
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for deferred_free_slot_allocator.
// Drives a directed table, then random request phases, and checks each result
// against a local model of the free stack and retire lists. Depends on dfsa_pkg.
module testbench;
    import dfsa_pkg::*;

    // Unused function code: the block must answer it with a plain OK.
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] ADDR_HANDLE   = {REG_HANDLE, 2'b00};

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int NUM_PHASES     = 5;
    localparam int RAND_PER_PHASE = 140;
    // Run the retire list fill sequence before this random phase.
    localparam int FILL_BEFORE    = 2;

    typedef struct {
        bit          is_cfg;
        bit          typed;
        logic [2:0]  addr;
        logic [31:0] data;
        t_in_item    req;
        t_out_item   want;
    } t_script_row;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ---------------------------------------------------------------------
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_data;
    logic [31:0] prdata;
    logic        pready;

    always #1 i_clk = ~i_clk;

    deferred_free_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ---------------------------------------------------------------------
    // Allocator model: free stack, bump counter, per-slot retire lists
    // ---------------------------------------------------------------------
    logic [10:0] cfg_capacity = '0;
    logic [15:0] cfg_handle   = '0;
    logic [9:0]  stack_mem [0:MAX_ELEMENTS-1];
    logic [9:0]  retire_mem [0:FRAME_SLOTS-1][0:MAX_ELEMENTS-1];
    int          retire_len [0:FRAME_SLOTS-1] = '{default: 0};
    int          stack_depth = 0;
    int          bump_next   = 0;

    t_out_item   result_q [$];   // results still owed by the block, oldest first
    logic [9:0]  held_slots [$]; // indices handed out and not yet released
    t_script_row script [$];
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          errors = 0;
    int          cycles = 0;

    function automatic t_out_item apply_request(t_in_item req);
        t_out_item res;
        int        s;
        int        cap;
        res = '0;
        res.status = ST_OK;
        s = int'(req.slot);
        // A capacity above the memory size behaves as the memory size.
        cap = (int'(cfg_capacity) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cfg_capacity);
        case (req.func)
            FN_ALLOC: begin
                if (req.count != 8'd1) begin
                    res.status = ST_BAD_COUNT;
                end else if (stack_depth > 0) begin
                    stack_depth--;
                    res.index = stack_mem[stack_depth];
                end else if (bump_next < cap) begin
                    res.index = bump_next[9:0];
                    bump_next++;
                end else begin
                    res.status = ST_NO_SPACE;
                end
            end
            FN_RELEASE: begin
                // Handle check wins over everything, even a bad slot.
                if (req.handle != cfg_handle) begin
                    res.status = ST_FOREIGN;
                end else if (s >= FRAME_SLOTS || retire_len[s] >= MAX_ELEMENTS) begin
                    res.status = ST_RETIRE_FULL;
                end else begin
                    retire_mem[s][retire_len[s]] = req.element;
                    retire_len[s]++;
                end
            end
            FN_FRAME: begin
                if (s < FRAME_SLOTS) begin
                    // Move oldest first; drop what no longer fits on the stack.
                    for (int k = 0; k < retire_len[s]; k++) begin
                        if (stack_depth >= MAX_ELEMENTS) break;
                        stack_mem[stack_depth] = retire_mem[s][k];
                        stack_depth++;
                    end
                    retire_len[s] = 0;
                end
            end
            default: ;
        endcase
        res.free_count  = stack_depth[10:0];
        res.next_unused = bump_next[10:0];
        return res;
    endfunction

    function automatic t_in_item make_item(logic [1:0] f, logic [7:0] c, logic [9:0] e,
                                           logic [15:0] h, logic [1:0] s);
        t_in_item it;
        it.func    = f;
        it.count   = c;
        it.element = e;
        it.handle  = h;
        it.slot    = s;
        return it;
    endfunction

    // Append a directed row; typed rows carry their result written out by hand.
    function automatic void add_row(bit typed, t_in_item req, logic [2:0] st,
                                    logic [9:0] idx, logic [10:0] fc, logic [10:0] nu);
        t_script_row row;
        row = '{default: '0};
        row.typed = typed;
        row.req   = req;
        row.want  = '{status: st, index: idx, free_count: fc, next_unused: nu};
        script.insert(script.size(), row);
    endfunction

    function automatic void add_cfg(logic [2:0] addr, logic [31:0] data);
        t_script_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.data   = data;
        script.insert(script.size(), row);
    endfunction

    // Mostly well-formed traffic: allocates, releases of held indices with the
    // primary handle, frame starts on live slots; the rest is noise.
    function automatic t_in_item make_request();
        t_in_item r;
        int       pick;
        int       pos;
        r = make_item(FN_ALLOC, 8'd1, 10'($urandom_range(MAX_ELEMENTS - 1)), cfg_handle,
                      2'($urandom_range(FRAME_SLOTS - 1)));
        pick = $urandom_range(99);
        if (pick >= 40 && pick < 75) begin
            r.func = FN_RELEASE;
            if (held_slots.size() != 0 && $urandom_range(3) != 0) begin
                pos = $urandom_range(held_slots.size() - 1);
                r.element = held_slots[pos];
                held_slots.delete(pos);
            end
        end else if (pick >= 75 && pick < 88) begin
            r.func = FN_FRAME;
        end else if (pick >= 88) begin
            r.func   = 2'($urandom_range(3));
            r.count  = 8'($urandom_range(255));
            r.handle = ($urandom_range(1) != 0) ? 16'($urandom_range(65535)) : cfg_handle;
            r.slot   = 2'($urandom_range(3));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driving: request channel, configuration port, drain
    // ---------------------------------------------------------------------
    // Present one request, wait for its transfer, then book its result.
    task automatic send_item(t_in_item it, bit typed, t_out_item hand_want);
        int        gap;
        t_out_item res;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        res = apply_request(it);
        if (it.func == FN_ALLOC && res.status == ST_OK) begin
            held_slots.insert(held_slots.size(), res.index);
        end
        result_q.insert(result_q.size(), typed ? hand_want : res);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CAPACITY) cfg_capacity = data[10:0];
        else cfg_handle = data[15:0];
        // Leave the bus idle before the next setup phase.
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every booked result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: random stall, result check, watchdog
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && out_valid && out_ready) begin
            if (result_q.size() == 0) begin
                $error("result transfer with nothing outstanding: status %0d index %0d",
                       out_data.status, out_data.index);
                errors++;
            end else begin
                exp_res = result_q.pop_front();
                if (out_data.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
                    errors++;
                end
                if (out_data.index !== exp_res.index) begin
                    $error("index: expected %0d, got %0d", exp_res.index, out_data.index);
                    errors++;
                end
                if (out_data.free_count !== exp_res.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           exp_res.free_count, out_data.free_count);
                    errors++;
                end
                if (out_data.next_unused !== exp_res.next_unused) begin
                    $error("next_unused: expected %0d, got %0d",
                           exp_res.next_unused, out_data.next_unused);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [10:0] phase_cap [0:NUM_PHASES-1];
        int          phase_src [0:NUM_PHASES-1];
        int          phase_snk [0:NUM_PHASES-1];

        // Small capacity to hit the bump limit, then past the bound, exactly
        // the bound, zero, and a random one; idling varies phase by phase.
        phase_cap = '{11'd6, 11'd2047, 11'd1024, 11'd0, 11'($urandom_range(2047))};
        phase_src = '{0, 47, 0, 16, 0};
        phase_snk = '{0, 0, 47, 16, 0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Reset leaves capacity 0 and primary handle 0.
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'h0000, 2'd0), ST_NO_SPACE, 0, 0, 0);
        add_row(1, make_item(FN_ALLOC, 8'd0, 10'd0, 16'h0000, 2'd0), ST_BAD_COUNT, 0, 0, 0);
        add_row(1, make_item(FN_ALLOC, 8'd255, 10'd1023, 16'hFFFF, 2'd3),
                ST_BAD_COUNT, 0, 0, 0);
        // Unused function code with every other field at its top value.
        add_row(1, make_item(FN_UNUSED, 8'd255, 10'd1023, 16'hFFFF, 2'd3), ST_OK, 0, 0, 0);
        add_row(1, make_item(FN_RELEASE, 8'd1, 10'd5, 16'hFFFF, 2'd3), ST_FOREIGN, 0, 0, 0);
        // Matching handle into a slot that does not exist.
        add_row(1, make_item(FN_RELEASE, 8'd1, 10'd5, 16'h0000, 2'd3),
                ST_RETIRE_FULL, 0, 0, 0);
        add_row(1, make_item(FN_FRAME, 8'd0, 10'd0, 16'h0000, 2'd3), ST_OK, 0, 0, 0);
        // Released elements are taken as given, even never-allocated ones.
        add_row(1, make_item(FN_RELEASE, 8'd1, 10'd1023, 16'h0000, 2'd0), ST_OK, 0, 0, 0);
        add_row(1, make_item(FN_RELEASE, 8'd1, 10'd0, 16'h0000, 2'd0), ST_OK, 0, 0, 0);
        add_row(1, make_item(FN_RELEASE, 8'd1, 10'd512, 16'h0000, 2'd1), ST_OK, 0, 0, 0);
        add_row(1, make_item(FN_FRAME, 8'd1, 10'd0, 16'h0000, 2'd0), ST_OK, 0, 2, 0);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'h0000, 2'd0), ST_OK, 0, 1, 0);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'h0000, 2'd0), ST_OK, 1023, 0, 0);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'h0000, 2'd0), ST_NO_SPACE, 0, 0, 0);
        // Capacity above the memory size, all-ones handle.
        add_cfg(ADDR_CAPACITY, 32'd2047);
        add_cfg(ADDR_HANDLE, 32'h0000_FFFF);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'h0000, 2'd0), ST_OK, 0, 0, 1);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'h0000, 2'd0), ST_OK, 1, 0, 2);
        add_row(1, make_item(FN_RELEASE, 8'd1, 10'd1, 16'h0000, 2'd1), ST_FOREIGN, 0, 0, 2);
        add_row(0, make_item(FN_RELEASE, 8'd1, 10'd1, 16'hFFFF, 2'd2), ST_OK, 0, 0, 0);
        add_row(0, make_item(FN_FRAME, 8'd1, 10'd0, 16'hFFFF, 2'd1), ST_OK, 0, 0, 0);
        add_row(0, make_item(FN_FRAME, 8'd1, 10'd0, 16'hFFFF, 2'd2), ST_OK, 0, 0, 0);
        add_row(0, make_item(FN_ALLOC, 8'd1, 10'd0, 16'hFFFF, 2'd0), ST_OK, 0, 0, 0);
        add_cfg(ADDR_CAPACITY, 32'd2);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'hFFFF, 2'd0), ST_OK, 512, 0, 2);
        add_row(1, make_item(FN_ALLOC, 8'd1, 10'd0, 16'hFFFF, 2'd0), ST_NO_SPACE, 0, 0, 2);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain();
                reg_write(script[i].addr, script[i].data);
            end else begin
                send_item(script[i].req, script[i].typed, script[i].want);
            end
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == FILL_BEFORE) begin
                // Fill retire slot 0 to the brim, overflow it once, flush it
                // onto the stack, then flush a second slot into a full stack.
                src_idle_pct  = 16;
                snk_stall_pct = 16;
                while (retire_len[0] < MAX_ELEMENTS)
                    send_item(make_item(FN_RELEASE, 8'd1, 10'($urandom_range(1023)),
                                        cfg_handle, 2'd0), 0, '0);
                send_item(make_item(FN_RELEASE, 8'd1, 10'd7, cfg_handle, 2'd0), 0, '0);
                send_item(make_item(FN_FRAME, 8'd1, 10'd0, cfg_handle, 2'd0), 0, '0);
                repeat (3)
                    send_item(make_item(FN_RELEASE, 8'd1, 10'($urandom_range(1023)),
                                        cfg_handle, 2'd2), 0, '0);
                send_item(make_item(FN_FRAME, 8'd1, 10'd0, cfg_handle, 2'd2), 0, '0);
                drain();
            end
            src_idle_pct  = phase_src[p];
            snk_stall_pct = phase_snk[p];
            reg_write(ADDR_CAPACITY, 32'(phase_cap[p]));
            reg_write(ADDR_HANDLE, 32'($urandom_range(65535)));
            repeat (RAND_PER_PHASE) send_item(make_request(), 0, '0);
            drain();
        end

        // Keep the clock running to catch any stray result transfer.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
